FILE: sv/tile_sprite_scanline_renderer_top_assert.svh
// Assertion helpers for the renderer top file.
`ifndef TILE_SPRITE_SCANLINE_RENDERER_TOP_ASSERT_SVH
`define TILE_SPRITE_SCANLINE_RENDERER_TOP_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define TSSR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TSSR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/tssr_pkg.sv
package tssr_pkg;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_VRAM_WR = 2'd0,
    OP_OAM_WR  = 2'd1,
    OP_RENDER  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BG,
    S_SEL,
    S_DRAW,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e         opcode;
    logic [12:0] address;
    logic [7:0]  write_data;
    logic [7:0]  line;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
    logic [7:0]  window_x;
    logic [7:0]  window_y;
    logic [7:0]  lcd_control;
  } in_item_t;

  typedef struct packed {
    logic [47:0] pixel_group;
    logic [4:0]  group_index;
    logic        last;
  } out_item_t;

  localparam int unsigned VRAM_AW = 13;
  localparam logic [12:0] MAP_LOW  = 13'h1800;
  localparam logic [12:0] MAP_HIGH = 13'h1C00;
  localparam logic [7:0]  SCREEN_LINES = 8'd144;
  localparam logic [7:0]  WIN_X_MAX = 8'd166;

  // Bit positions in lcd_control.
  localparam int unsigned CTRL_ON      = 7;
  localparam int unsigned CTRL_WIN_MAP = 6;
  localparam int unsigned CTRL_WIN_ON  = 5;
  localparam int unsigned CTRL_TILES   = 4;
  localparam int unsigned CTRL_BG_MAP  = 3;
  localparam int unsigned CTRL_TALL    = 2;
  localparam int unsigned CTRL_SPR_ON  = 1;

endpackage

FILE: sv/tssr_vram.sv
module tssr_vram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [tssr_pkg::VRAM_AW-1:0] addr_i,
  input  logic [7:0]                  wdata_i,
  output logic [7:0]                  rdata_o
);
  import tssr_pkg::*;

  logic [7:0] mem [2**VRAM_AW];
  logic [7:0] rdata_q;

  // Single port: an optional write and a registered read each cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tile_sprite_scanline_renderer_top.sv
// Tile map and sprite scanline renderer.
// Items enter on item_i when start is high and busy is low. A video memory
// write or a sprite table write gives no result. A render item with the
// display bit set builds one line in the line store and then streams it out
// as (LINE_WIDTH+7)/8 results on result_o, one per cycle, each marked by
// result_valid_o for one cycle; the last one carries last.
// Render steps: per column the background does three video memory reads on
// its single port plus the line store write; each scanned sprite table
// entry is read, and each picked sprite has its two pattern bytes read and
// is then drawn pixel by pixel into the line store; then the result
// groups are read out of the line store.
// A render with the display off, or an unused opcode, gives nothing.
// After reset the block clears video memory and the sprite table, holding
// busy high meanwhile. The receiver cannot stall: results are shown
// exactly once and must be taken in the cycle they appear.
`include "tile_sprite_scanline_renderer_top_assert.svh"

module tile_sprite_scanline_renderer_top #(
  parameter int unsigned LINE_WIDTH       = 160,
  parameter int unsigned SPRITE_COUNT     = 40,
  parameter int unsigned SPRITES_PER_LINE = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  tssr_pkg::in_item_t  item_i,
  output logic                busy,
  output logic                result_valid_o,
  output tssr_pkg::out_item_t result_o
);
  import tssr_pkg::*;

  localparam int unsigned GROUPS      = (LINE_WIDTH + 7) / 8;
  localparam int unsigned ROW_W       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned COL_W       = $clog2(LINE_WIDTH);
  localparam int unsigned TABLE_BYTES = SPRITE_COUNT * 4;
  localparam int unsigned OAM_AW      = $clog2(TABLE_BYTES);
  localparam int unsigned SPR_W       = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int unsigned N_W         = $clog2(SPRITES_PER_LINE + 1);
  localparam int unsigned CH_W        = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] x;
    logic       pal;
    logic       xflip;
  } spr_t;

  state_e state_q, state_d;
  in_item_t req_q;
  logic [2:0] phase_q;
  logic [COL_W-1:0] col_q;
  logic [VRAM_AW-1:0] clr_q;
  logic [SPR_W-1:0] spr_q;
  logic [N_W-1:0] n_q;
  logic [CH_W-1:0] dk_q;
  logic [2:0] pix_q;
  logic [ROW_W-1:0] orow_q, out_idx_q;
  logic out_v_q;

  // Payload registers.
  logic [VRAM_AW-1:0] addr_q;
  logic [7:0] lo_q, y_q, x_q, tile_q;
  logic pal_q, xflip_q;
  spr_t chosen_q [SPRITES_PER_LINE];

  // Video memory port.
  logic vr_we;
  logic [VRAM_AW-1:0] vr_addr;
  logic [7:0] vr_wdata, vr_rdata;

  tssr_vram u_vram (
    .clk_i   (clk_i),
    .we_i    (vr_we),
    .addr_i  (vr_addr),
    .wdata_i (vr_wdata),
    .rdata_o (vr_rdata)
  );

  // Sprite table and line store.
  logic [7:0] oam_mem [TABLE_BYTES];
  logic [7:0] oam_rd_q;
  logic oam_we;
  logic [OAM_AW-1:0] oam_waddr, oam_raddr;
  logic [7:0] oam_wdata;
  logic [47:0] ls_mem [GROUPS];
  logic [47:0] ls_rd_q;
  logic ls_we;
  logic [ROW_W-1:0] ls_wrow;
  logic [2:0] ls_lane;
  logic [5:0] ls_px;

  logic accept;
  logic [7:0] ctrl, col8;
  assign accept = start && !busy;
  assign ctrl   = req_q.lcd_control;
  assign col8   = 8'(col_q);

  // Background and window address generation for the current column.
  logic win_en, in_win;
  logic [7:0] mx, my;
  logic [12:0] map_base, map_addr, tile_addr;
  logic tile_low;
  logic [2:0] bitn;
  logic [5:0] bg_px;

  always_comb begin
    win_en = ctrl[CTRL_WIN_ON] && (req_q.window_y <= req_q.line) &&
             (req_q.window_y < SCREEN_LINES) && (req_q.window_x <= WIN_X_MAX);
    in_win = win_en && (({1'b0, col8} + 9'd7) >= {1'b0, req_q.window_x});
    if (in_win) begin
      mx = 8'(col8 + 8'd7 - req_q.window_x);
      my = 8'(req_q.line - req_q.window_y);
      map_base = ctrl[CTRL_WIN_MAP] ? MAP_HIGH : MAP_LOW;
    end else begin
      mx = 8'(req_q.scroll_x + col8);
      my = 8'(req_q.scroll_y + req_q.line);
      map_base = ctrl[CTRL_BG_MAP] ? MAP_HIGH : MAP_LOW;
    end
    map_addr  = map_base + {3'b000, my[7:3], mx[7:3]};
    tile_low  = !(ctrl[CTRL_TILES] || vr_rdata[7]);
    tile_addr = {tile_low, vr_rdata, my[2:0], 1'b0};
    bitn      = 3'd7 - mx[2:0];
    bg_px     = {3'b000, in_win, vr_rdata[bitn], lo_q[bitn]};
  end

  // Sprite row test, done when the flags byte arrives.
  logic [9:0] spr_r;
  logic spr_hit, spr_last, tall;
  logic [3:0] row4;
  logic [7:0] tile_n;
  logic [2:0] row3;
  logic [12:0] spr_addr;
  logic [7:0] flags;

  always_comb begin
    tall    = ctrl[CTRL_TALL];
    flags   = oam_rd_q;
    spr_r   = {2'b00, req_q.line} + 10'd16 - {2'b00, y_q};
    spr_hit = tall ? (spr_r < 10'd16) : (spr_r < 10'd8);
    row4    = spr_r[3:0];
    if (flags[6]) begin
      row4 = tall ? (4'd15 - spr_r[3:0]) : (4'd7 - spr_r[3:0]);
    end
    if (tall) begin
      tile_n = {tile_q[7:1], row4[3]};
    end else begin
      tile_n = tile_q;
    end
    row3     = row4[2:0];
    spr_addr = {1'b0, tile_n, row3, 1'b0};
    spr_last = (spr_q == SPR_W'(SPRITE_COUNT - 1)) ||
               ((phase_q == 3'd7) && (N_W'(n_q + 1'b1) == N_W'(SPRITES_PER_LINE)));
  end

  // Sprite drawing for the current pixel.
  spr_t cur;
  logic [8:0] dsum, dcol;
  logic dvalid;
  logic [2:0] dbit;
  logic [1:0] dcolour;

  always_comb begin
    cur     = chosen_q[dk_q];
    dsum    = {1'b0, cur.x} + {6'b0, pix_q};
    dcol    = dsum - 9'd8;
    dvalid  = (dsum >= 9'd8) && (dcol < 9'(LINE_WIDTH));
    dbit    = cur.xflip ? pix_q : (3'd7 - pix_q);
    dcolour = {cur.hi[dbit], cur.lo[dbit]};
  end

  // Next state and memory port control.
  always_comb begin
    state_d   = state_q;
    vr_we     = 1'b0;
    vr_addr   = addr_q;
    vr_wdata  = item_i.write_data;
    oam_we    = 1'b0;
    oam_waddr = OAM_AW'(item_i.address);
    oam_wdata = item_i.write_data;
    oam_raddr = OAM_AW'({spr_q, phase_q[1:0]});
    ls_we     = 1'b0;
    ls_wrow   = ROW_W'(col8 >> 3);
    ls_lane   = col8[2:0];
    ls_px     = bg_px;
    unique case (state_q)
      S_CLEAR: begin
        vr_we     = 1'b1;
        vr_addr   = clr_q;
        vr_wdata  = 8'd0;
        oam_we    = (clr_q < 13'(TABLE_BYTES));
        oam_waddr = OAM_AW'(clr_q);
        oam_wdata = 8'd0;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        vr_addr = item_i.address;
        if (accept) begin
          unique case (item_i.opcode)
            OP_VRAM_WR: vr_we = 1'b1;
            OP_OAM_WR: oam_we = (item_i.address < 13'(TABLE_BYTES));
            OP_RENDER: begin
              if (item_i.lcd_control[CTRL_ON]) begin
                state_d = S_BG;
              end
            end
            default: ;
          endcase
        end
      end
      S_BG: begin
        case (phase_q)
          3'd0: vr_addr = map_addr;
          3'd1: vr_addr = tile_addr;
          3'd2: vr_addr = addr_q | 13'd1;
          default: begin
            ls_we = 1'b1;
            if (col_q == COL_W'(LINE_WIDTH - 1)) begin
              state_d = ctrl[CTRL_SPR_ON] ? S_SEL : S_DRAW;
            end
          end
        endcase
      end
      S_SEL: begin
        case (phase_q)
          3'd4: begin
            vr_addr = spr_addr;
            if (!spr_hit && spr_last) begin
              state_d = S_DRAW;
            end
          end
          // The high byte is read in phases 5 and 6 so it is on the port when the
          // chosen entry is stored in phase 7.
          3'd5, 3'd6: vr_addr = addr_q | 13'd1;
          3'd7: begin
            if (spr_last) begin
              state_d = S_DRAW;
            end
          end
          default: ;
        endcase
      end
      S_DRAW: begin
        ls_wrow = ROW_W'(dcol[7:0] >> 3);
        ls_lane = dcol[2:0];
        ls_px   = {1'b1, 2'b00, cur.pal, dcolour};
        if (n_q == '0) begin
          state_d = S_OUT;
        end else begin
          ls_we = dvalid && (dcolour != 2'b00);
          if ((pix_q == 3'd7) && (dk_q == '0)) begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (orow_q == ROW_W'(GROUPS - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      phase_q   <= '0;
      col_q     <= '0;
      clr_q     <= '0;
      spr_q     <= '0;
      n_q       <= '0;
      dk_q      <= '0;
      pix_q     <= '0;
      orow_q    <= '0;
      out_idx_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_v_q   <= (state_q == S_OUT);
      out_idx_q <= orow_q;
      case (state_q)
        S_CLEAR: clr_q <= clr_q + 1'b1;
        S_IDLE: begin
          phase_q <= '0;
          col_q   <= '0;
          spr_q   <= '0;
          n_q     <= '0;
          pix_q   <= '0;
          orow_q  <= '0;
        end
        S_BG: begin
          phase_q <= (phase_q == 3'd3) ? 3'd0 : phase_q + 1'b1;
          if (phase_q == 3'd3) begin
            col_q <= col_q + 1'b1;
          end
        end
        S_SEL: begin
          if ((phase_q == 3'd4 && !spr_hit) || phase_q == 3'd7) begin
            phase_q <= '0;
            spr_q   <= spr_q + 1'b1;
          end else begin
            phase_q <= phase_q + 1'b1;
          end
          if (phase_q == 3'd7) begin
            n_q  <= n_q + 1'b1;
            dk_q <= CH_W'(n_q);
          end
        end
        S_DRAW: begin
          pix_q <= pix_q + 1'b1;
          if (pix_q == 3'd7) begin
            dk_q <= dk_q - 1'b1;
          end
        end
        S_OUT: orow_q <= orow_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= item_i;
    end
    if (state_q == S_BG && phase_q == 3'd1) begin
      addr_q <= tile_addr;
    end
    if ((state_q == S_BG && phase_q == 3'd2) || (state_q == S_SEL && phase_q == 3'd5)) begin
      lo_q <= vr_rdata;
    end
    if (state_q == S_SEL) begin
      case (phase_q)
        3'd1: y_q <= oam_rd_q;
        3'd2: x_q <= oam_rd_q;
        3'd3: tile_q <= oam_rd_q;
        3'd4: begin
          addr_q  <= spr_addr;
          pal_q   <= flags[4];
          xflip_q <= flags[5];
        end
        3'd7: chosen_q[CH_W'(n_q)] <= '{lo: lo_q, hi: vr_rdata, x: x_q,
                                         pal: pal_q, xflip: xflip_q};
        default: ;
      endcase
    end
  end

  // Sprite table and line store memories.
  always_ff @(posedge clk_i) begin
    if (oam_we) begin
      oam_mem[oam_waddr] <= oam_wdata;
    end
    oam_rd_q <= oam_mem[oam_raddr];
    if (ls_we) begin
      ls_mem[ls_wrow][ls_lane*6 +: 6] <= ls_px;
    end
    ls_rd_q <= ls_mem[orow_q];
  end

  // Result; lanes past the end of the line read as zero.
  always_comb begin
    result_o.pixel_group = ls_rd_q;
    for (int j = 0; j < 8; j++) begin
      if (9'({out_idx_q, 3'(j)}) >= 9'(LINE_WIDTH)) begin
        result_o.pixel_group[j*6 +: 6] = 6'd0;
      end
    end
    result_o.group_index = 5'(out_idx_q);
    result_o.last        = (out_idx_q == ROW_W'(GROUPS - 1));
  end

  assign result_valid_o = out_v_q;
  assign busy           = (state_q != S_IDLE);

  `TSSR_ASSERT(a_groups_contiguous, result_valid_o && !result_o.last |=> result_valid_o, "line stream broke before its last group")
  `TSSR_ASSERT(a_stream_ends, result_valid_o && result_o.last |=> !result_valid_o, "result after last group")
  `TSSR_ASSERT_ALWAYS(a_index_range, result_valid_o |-> (result_o.group_index < 5'(GROUPS)), "group index past line")

endmodule
